@@ rtl/aes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

    localparam int Rounds = 10;
    localparam int NumKeys = Rounds + 1;
    localparam int KeyIdxW = $clog2(NumKeys);

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    // Round operation selects for the shared round unit.
    typedef enum logic [2:0] {
        OP_ADD   = 3'b001,
        OP_ROUND = 3'b010,
        OP_LAST  = 3'b100
    } round_op_t;

    typedef struct packed {
        round_op_t op;
        logic      inv;
    } round_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

endpackage
`default_nettype wire

@@ rtl/aes_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One AES round or key addition on a 128-bit state, forward or inverse, shared by all rounds.
module aes_round (
    input  wire logic [127:0]          state_in,
    input  wire logic [127:0]          round_key,
    input  wire aes_pkg::round_ctl_t   ctl,
    output logic [127:0]               state_out
);
    import aes_pkg::*;

    logic [7:0] s   [16];
    logic [7:0] sb  [16];
    logic [7:0] kb  [16];
    logic [7:0] mx  [16];
    logic [7:0] fin [16];
    logic [7:0] a0, a1, a2, a3, x0, x1, x2, x3, y0, y1;

    always_comb begin
        y0 = 8'h00;
        y1 = 8'h00;
        for (int i = 0; i < 16; i++) begin
            s[i]  = state_in[127 - 8*i -: 8];
            kb[i] = round_key[127 - 8*i -: 8];
        end
        // Byte substitution combined with the row shift.
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (ctl.inv) begin
                    sb[r + 4*c] = inv_sbox(s[r + 4*((c - r + 4) % 4)]);
                end else begin
                    sb[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
                end
            end
        end
        // Column mix; the inverse direction adds the key before mixing.
        for (int c = 0; c < 4; c++) begin
            if (ctl.inv) begin
                a0 = sb[4*c] ^ kb[4*c];
                a1 = sb[4*c+1] ^ kb[4*c+1];
                a2 = sb[4*c+2] ^ kb[4*c+2];
                a3 = sb[4*c+3] ^ kb[4*c+3];
                // Pre-condition with {04}/{05} terms, then forward mix.
                y0 = xtime(xtime(a0 ^ a2));
                y1 = xtime(xtime(a1 ^ a3));
                a0 = a0 ^ y0;
                a1 = a1 ^ y1;
                a2 = a2 ^ y0;
                a3 = a3 ^ y1;
            end else begin
                a0 = sb[4*c];
                a1 = sb[4*c+1];
                a2 = sb[4*c+2];
                a3 = sb[4*c+3];
            end
            x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
            mx[4*c]   = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            mx[4*c+1] = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            mx[4*c+2] = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            mx[4*c+3] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        for (int i = 0; i < 16; i++) begin
            case (ctl.op)
                OP_ADD:   fin[i] = s[i] ^ kb[i];
                OP_ROUND: fin[i] = ctl.inv ? mx[i] : (mx[i] ^ kb[i]);
                OP_LAST:  fin[i] = sb[i] ^ kb[i];
                default:  fin[i] = s[i];
            endcase
            state_out[127 - 8*i -: 8] = fin[i];
        end
    end

endmodule
`default_nettype wire

@@ rtl/aes128_block_cipher.sv @@
`timescale 1ns / 1ps
`default_nettype none
// AES-128 ECB engine. Writing key_high or key_low starts a key expansion that
// fills the eleven-entry round-key memory: the key is loaded first, then one
// round key is written per cycle, and s_ready stays low until the expansion
// ends. An accepted block makes the initial key addition and ten passes
// through the single shared round unit, with the first round key read from
// memory in the acceptance cycle. The engine takes no new block while one is
// in the rounds; the round unit and the one-read-port key memory set this.
// The result moves into an output register, so the next block is taken while
// a result waits; the engine stalls only when a finished block finds the
// previous result still unread. The mode register may change between blocks
// without re-expansion.
module aes128_block_cipher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_block_high,
    input  wire logic [63:0] s_block_low,
    input  wire logic        s_last_block,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_high,
    output logic [63:0]      m_result_low,
    output logic             m_result_last
);
    import aes_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_KEXP  = 4'b0010,
        ST_CIPH  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [63:0]          key_high_reg, key_low_reg;
    logic                 mode_reg;
    logic [127:0]         rk_mem [NumKeys];
    logic [127:0]         rk_rd_reg;
    logic [KeyIdxW-1:0]   rd_addr;
    logic [KeyIdxW-1:0]   cnt_reg;
    logic [127:0]         kexp_reg;
    logic [7:0]           rcon_reg;
    logic [127:0]         blk_reg;
    logic                 last_reg;
    logic                 inv_reg;
    logic                 kick_reg;
    logic [127:0]         rnd_out;
    round_ctl_t           ctl;
    logic [31:0]          w0, w1, w2, w3, tw, n0, n1, n2, n3;
    logic [127:0]         kexp_next;
    logic                 key_write;
    logic                 last_round;
    logic                 out_free;
    logic                 load_out;
    logic                 out_valid_reg;
    logic [127:0]         out_data_reg;
    logic                 out_last_reg;

    assign key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            mode_reg     <= 1'b0;
            kick_reg     <= 1'b0;
        end else begin
            kick_reg <= key_write;
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_HIGH: key_high_reg <= cfg_data;
                    REG_KEY_LOW:  key_low_reg  <= cfg_data;
                    REG_MODE:     mode_reg     <= cfg_data[0];
                    default:      ;
                endcase
            end
        end
    end

    // Next round key from the current one.
    always_comb begin
        w0 = kexp_reg[127:96];
        w1 = kexp_reg[95:64];
        w2 = kexp_reg[63:32];
        w3 = kexp_reg[31:0];
        tw = {sbox(w3[23:16]) ^ rcon_reg, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        n0 = w0 ^ tw;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        kexp_next = {n0, n1, n2, n3};
    end

    // Round-key memory: written during expansion, read one entry per cycle.
    always_comb begin
        if (state_reg == ST_IDLE) begin
            rd_addr = mode_reg ? KeyIdxW'(Rounds) : '0;
        end else if (inv_reg) begin
            rd_addr = cnt_reg - KeyIdxW'(1);
        end else begin
            rd_addr = cnt_reg + KeyIdxW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_KEXP) begin
            rk_mem[cnt_reg] <= kexp_reg;
        end
        rk_rd_reg <= rk_mem[rd_addr];
    end

    always_comb begin
        ctl.inv = inv_reg;
        if (cnt_reg == '0 && !inv_reg || cnt_reg == KeyIdxW'(Rounds) && inv_reg) begin
            ctl.op = OP_ADD;
        end else if (cnt_reg == KeyIdxW'(Rounds) || cnt_reg == '0) begin
            ctl.op = OP_LAST;
        end else begin
            ctl.op = OP_ROUND;
        end
    end

    aes_round u_round (
        .state_in  (blk_reg),
        .round_key (rk_rd_reg),
        .ctl       (ctl),
        .state_out (rnd_out)
    );

    // The final pass of a block, and whether the output register can take it.
    assign last_round = (inv_reg && cnt_reg == '0) || (!inv_reg && cnt_reg == KeyIdxW'(Rounds));
    assign out_free   = !out_valid_reg || m_ready;
    assign load_out   = ((state_reg == ST_CIPH && last_round) || state_reg == ST_OUT) && out_free;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (kick_reg) begin
                    state_next = ST_KEXP;
                end else if (s_valid) begin
                    state_next = ST_CIPH;
                end
            end
            ST_KEXP: begin
                if (cnt_reg == KeyIdxW'(Rounds)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CIPH: begin
                if (last_round) begin
                    state_next = out_free ? ST_IDLE : ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE) && !kick_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            inv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (kick_reg) begin
                        cnt_reg <= '0;
                    end else if (s_valid) begin
                        inv_reg <= mode_reg;
                        cnt_reg <= mode_reg ? KeyIdxW'(Rounds) : '0;
                    end
                end
                ST_KEXP: cnt_reg <= cnt_reg + KeyIdxW'(1);
                ST_CIPH: begin
                    cnt_reg <= inv_reg ? cnt_reg - KeyIdxW'(1) : cnt_reg + KeyIdxW'(1);
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && kick_reg) begin
            kexp_reg <= {key_high_reg, key_low_reg};
            rcon_reg <= 8'h01;
        end else if (state_reg == ST_KEXP) begin
            kexp_reg <= kexp_next;
            rcon_reg <= xtime(rcon_reg);
        end
        if (s_valid && s_ready) begin
            blk_reg  <= {s_block_high, s_block_low};
            last_reg <= s_last_block;
        end else if (state_reg == ST_CIPH) begin
            blk_reg <= rnd_out;
        end
    end

    // Output register: holds one finished transaction until it is read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (load_out) begin
            out_data_reg <= (state_reg == ST_CIPH) ? rnd_out : blk_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_high = out_data_reg[127:64];
    assign m_result_low  = out_data_reg[63:0];
    assign m_result_last = out_last_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CIPH) |-> !s_ready) else $error("accept while busy");
    a_out_after_ciph: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_CIPH || state_reg == ST_OUT))
        else $error("output without rounds");
    a_kexp_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_KEXP) |-> (cnt_reg <= KeyIdxW'(Rounds))) else $error("key index");
`endif

endmodule
`default_nettype wire

@@ test/aes_checker.sv @@
`timescale 1ns / 1ps
module aes_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    input  logic        s_last_block,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [63:0] m_result_high,
    input  logic [63:0] m_result_low,
    input  logic        m_result_last,
    output int          errors,
    output int          pending
);
    import aes_pkg::*;

    typedef struct {
        logic [127:0] data;
        logic         last;
    } cipher_out_t;

    cipher_out_t  expected_q [$];
    logic [7:0]   fwd_sub [256];
    logic [7:0]   inv_sub [256];
    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic         decrypting;
    logic [127:0] round_keys [NumKeys];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] n);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (n[i]) acc ^= x;
            x = dbl(x);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] a, input int k);
        return (a << k) | (a >> (8 - k));
    endfunction

    // Build the substitution tables from the field inverse and the affine map.
    initial begin
        logic [7:0] inv_elem;
        logic [7:0] sb;
        for (int v = 0; v < 256; v++) begin
            inv_elem = 8'h00;
            if (v != 0) begin
                // a^254 is the multiplicative inverse in GF(2^8).
                inv_elem = 8'h01;
                for (int e = 0; e < 254; e++) inv_elem = gmul(inv_elem, v[7:0]);
            end
            sb = inv_elem ^ rotl8(inv_elem, 1) ^ rotl8(inv_elem, 2) ^ rotl8(inv_elem, 3)
                 ^ rotl8(inv_elem, 4) ^ 8'h63;
            fwd_sub[v] = sb;
            inv_sub[sb] = v[7:0];
        end
    end

    function automatic logic [7:0] byte_of(input logic [127:0] s, input int i);
        return s[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) t[127 - 8 * (r + 4 * c) -: 8] = inv_sub[byte_of(s, r + 4 * ((c - r + 4) & 3))];
                else t[127 - 8 * (r + 4 * c) -: 8] = fwd_sub[byte_of(s, r + 4 * ((c + r) & 3))];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [7:0]   coef [4];
        logic [7:0]   v;
        logic [127:0] t;
        if (inv) coef = '{8'h0E, 8'h0B, 8'h0D, 8'h09};
        else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = 8'h00;
                for (int k = 0; k < 4; k++) v ^= gmul(byte_of(s, 4 * c + k), coef[(k - r + 4) & 3]);
                t[127 - 8 * (4 * c + r) -: 8] = v;
            end
        end
        return t;
    endfunction

    // Key schedule from the current key register pair.
    function automatic void expand_keys();
        logic [31:0] w [4 * NumKeys];
        logic [31:0] tw;
        logic [7:0]  rc;
        rc = 8'h01;
        {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
        for (int i = 4; i < 4 * NumKeys; i++) begin
            tw = w[i - 1];
            if ((i & 3) == 0) begin
                tw = {fwd_sub[tw[23:16]] ^ rc, fwd_sub[tw[15:8]], fwd_sub[tw[7:0]],
                      fwd_sub[tw[31:24]]};
                rc = dbl(rc);
            end
            w[i] = w[i - 4] ^ tw;
        end
        for (int r = 0; r < NumKeys; r++)
            round_keys[r] = {w[4 * r], w[4 * r + 1], w[4 * r + 2], w[4 * r + 3]};
    endfunction

    function automatic logic [127:0] cipher_block(input logic [127:0] blk);
        logic [127:0] s;
        if (!decrypting) begin
            s = blk ^ round_keys[0];
            for (int r = 1; r < Rounds; r++)
                s = mix_columns(sub_shift(s, 1'b0), 1'b0) ^ round_keys[r];
            s = sub_shift(s, 1'b0) ^ round_keys[Rounds];
        end else begin
            s = blk ^ round_keys[Rounds];
            for (int r = Rounds - 1; r >= 1; r--)
                s = mix_columns(sub_shift(s, 1'b1) ^ round_keys[r], 1'b1);
            s = sub_shift(s, 1'b1) ^ round_keys[0];
        end
        return s;
    endfunction

    assign pending = expected_q.size();

    // Track configuration, predict on input transactions, compare on output ones.
    always @(posedge aclk) begin
        cipher_out_t exp_item;
        if (!aresetn) begin
            key_hi = 64'h0;
            key_lo = 64'h0;
            decrypting = 1'b0;
            errors <= 0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_KEY_HIGH: begin
                        key_hi = cfg_data;
                        expand_keys();
                    end
                    REG_KEY_LOW: begin
                        key_lo = cfg_data;
                        expand_keys();
                    end
                    REG_MODE: begin
                        decrypting = cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                exp_item.data = cipher_block({s_block_high, s_block_low});
                exp_item.last = s_last_block;
                expected_q.push_back(exp_item);
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result %h %h last %b", $time,
                             m_result_high, m_result_low, m_result_last);
                    errors <= errors + 1;
                end else begin
                    exp_item = expected_q.pop_front();
                    if ({m_result_high, m_result_low} !== exp_item.data
                        || m_result_last !== exp_item.last) begin
                        $display("%0t: result mismatch expected %h last %b actual %h%h last %b",
                                 $time, exp_item.data, exp_item.last,
                                 m_result_high, m_result_low, m_result_last);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import aes_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_block_high;
    logic [63:0] s_block_low;
    logic        s_last_block;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;
    logic        m_result_last;
    int          errors;
    int          pending;
    logic        quiet;
    int          stall_count;

    aes128_block_cipher u_top (.*);

    aes_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = 64'h0;
        s_valid = 1'b0;
        s_block_high = 64'h0;
        s_block_low = 64'h0;
        s_last_block = 1'b0;
        m_ready = 1'b0;
        quiet = 1'b0;
    end

    // Result side backpressure: random stall bursts until the final phase.
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (quiet || $urandom_range(0, 2) != 0) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= 3000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One register write, then time for any key expansion to finish.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        repeat (16) @(posedge aclk);
    endtask

    // Let every outstanding block drain before touching registers.
    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_block_high <= hi;
        s_block_low <= lo;
        s_last_block <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        drain();
    endtask

    task automatic random_blocks(input int count);
        for (int i = 0; i < count; i++)
            send_block({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 1));
        end_burst();
    endtask

    initial begin
        logic [63:0] hi;
        logic [63:0] lo;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Standard test key and vector, then the block extremes, both directions.
        write_reg(REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        write_reg(REG_MODE, 64'h0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        send_block(64'h0, 64'h0, 1'b1);
        send_block('1, '1, 1'b0);
        send_block('1, 64'h0, 1'b1);
        end_burst();
        // Mode change alone keeps the round keys.
        write_reg(REG_MODE, 64'h1);
        send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
        send_block(64'h0, 64'h0, 1'b0);
        send_block('1, '1, 1'b1);
        end_burst();
        // Out-of-range index must be ignored; only bit 0 of the mode counts.
        write_reg(2'd3, '1);
        write_reg(REG_MODE, 64'hfffffffffffffffe);
        send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
        end_burst();
        // All-zero and all-one keys.
        write_reg(REG_KEY_HIGH, 64'h0);
        write_reg(REG_KEY_LOW, 64'h0);
        send_block(64'h0, 64'h0, 1'b0);
        send_block('1, '1, 1'b1);
        end_burst();
        write_reg(REG_KEY_HIGH, '1);
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_MODE, 64'h1);
        send_block(64'h0, 64'h0, 1'b1);
        send_block('1, '1, 1'b0);
        end_burst();
        // Partial key update: only the low half changes.
        write_reg(REG_KEY_LOW, 64'h0);
        send_block(64'h8000000000000000, 64'h1, 1'b1);
        end_burst();

        // Random phases with random keys and modes, sometimes a partial update.
        for (int ph = 0; ph < 12; ph++) begin
            hi = {$urandom, $urandom};
            lo = {$urandom, $urandom};
            if (ph == 11) quiet = 1'b1;
            case ($urandom_range(0, 2))
                0: write_reg(REG_KEY_HIGH, hi);
                1: write_reg(REG_KEY_LOW, lo);
                default: begin
                    write_reg(REG_KEY_HIGH, hi);
                    write_reg(REG_KEY_LOW, lo);
                end
            endcase
            write_reg(REG_MODE, {$urandom, $urandom});
            random_blocks(120);
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
